// ===== sv/gps_pkg.sv =====
`default_nettype none
package gps_pkg;
    localparam logic [15:0] UNITY_RATIO = 16'd16384;
    localparam int GAIN_ONE = 8388608;
    localparam logic [31:0] SEED_A = 32'd1243598713;
    localparam logic [31:0] SEED_B = 32'd3093459404;
    localparam logic [31:0] SEED_C = 32'd1821928721;
    localparam logic [2:0] REG_RATIO = 3'd0;
    localparam logic [2:0] REG_PDISP = 3'd1;
    localparam logic [2:0] REG_TDISP = 3'd2;
    localparam logic [2:0] REG_FRAME = 3'd3;
    localparam logic [2:0] REG_RAMP  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RESTART1, ST_RESTART2, ST_RESTART3, ST_HEAD, ST_TAPWAIT,
        ST_TAPACC, ST_MUL, ST_SUM, ST_WRITE, ST_OUT
    } t_state;

    function automatic logic [31:0] mix_hash(input logic [31:0] hi);
        logic [31:0] h;
        h = hi;
        h = h + ~(h << 15);
        h = h ^ (h >> 10);
        h = h + (h << 3);
        h = h ^ (h >> 6);
        h = h + ~(h << 11);
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [31:0] seed_a();
        logic [31:0] s;
        s = SEED_A ^ mix_hash(32'd0);
        return (s < 32'd2) ? SEED_A : s;
    endfunction
    function automatic logic [31:0] seed_b();
        logic [31:0] s;
        s = SEED_B ^ mix_hash(32'd0);
        return (s < 32'd8) ? SEED_B : s;
    endfunction
    function automatic logic [31:0] seed_c();
        logic [31:0] s;
        s = SEED_C ^ mix_hash(32'd0);
        return (s < 32'd16) ? SEED_C : s;
    endfunction
endpackage
`default_nettype wire

// ===== sv/gps_ram.sv =====
`default_nettype none
module gps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/gps_rng.sv =====
`default_nettype none
// Three-part Tausworthe generator; steps when i_step.
module gps_rng (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clear,
    input  wire logic        i_step,
    output logic      [31:0] o_word
);
    import gps_pkg::*;
    logic [31:0] r_a, r_b, r_c, n_a, n_b, n_c;
    always_comb begin
        n_a = ((r_a & 32'hFFFF_FFFE) << 12) ^ (((r_a << 13) ^ r_a) >> 19);
        n_b = ((r_b & 32'hFFFF_FFF8) << 4) ^ (((r_b << 2) ^ r_b) >> 25);
        n_c = ((r_c & 32'hFFFF_FFF0) << 17) ^ (((r_c << 3) ^ r_c) >> 11);
    end
    assign o_word = n_a ^ n_b ^ n_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_a <= seed_a();
            r_b <= seed_b();
            r_c <= seed_c();
        end else if (i_step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
        end
    end
endmodule
`default_nettype wire

// ===== sv/granular_pitch_shifter.sv =====
`default_nettype none
// channel   | dir | handshake                 | payload
// s_axis    | in  | s_axis_tvalid/tready      | tdata: sample_in
// m_axis    | out | m_axis_tvalid/tready      | tdata: sample_out
// cfg       | in  | i_cfg_valid/o_cfg_ready   | i_cfg_index, i_cfg_data
// In bypass an accepted word is loaded straight into the output register
// and handed out through the output state. Otherwise each of four heads
// runs through address, two serial delay memory reads through the single
// read port, interpolation, gain multiply and accumulate, followed by
// write-back and output; when a head restarts, the random draws and the
// start delay come first. A new word is taken only in idle, after the last.
// Reset is synchronous active low; delay memory is never cleared: the
// warm-up rule hides unwritten entries. Output waits in a register; the
// next word is accepted once that register is free.
module granular_pitch_shifter #(
    parameter int DELAY_DEPTH  = 8192,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // [SW-1:0] sample_in
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata, // [SW-1:0] sample_out
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [22:0]             i_cfg_data
);
    import gps_pkg::*;
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = ((SAMPLE_WIDTH+7)/8)*8;
    localparam int ISH = (SW > 22) ? SW - 22 : 0;
    localparam int WCW = AW + 1;

    logic [15:0] r_ratio, r_pdisp;
    logic [13:0] r_tdisp;
    logic [11:0] r_frame;
    logic [22:0] r_ramp;

    t_state r_state, n_state;
    logic [AW-1:0] r_wp;
    logic [WCW-1:0] r_warm;
    logic [31:0] r_delay [4];
    logic signed [19:0] r_rate [4];
    logic signed [24:0] r_gain [4];
    logic signed [24:0] r_grate [4];
    logic [11:0] r_gcnt;
    logic [1:0] r_stage, r_h;
    logic [SW-1:0] r_x;
    logic signed [SW-1:0] r_d1;
    logic signed [SW+18:0] r_interp;
    logic signed [SW+44:0] r_prod, r_sum;
    logic signed [39:0] r_r36;
    logic [SW-1:0] r_out;
    logic r_ovalid, r_clear;
    logic [AW-1:0] r_rd;
    logic [15:0] r_frac;
    logic r_z1, r_z2, r_warmf;

    logic [AW-1:0] ram_raddr;
    logic [SW-1:0] ram_rdata;
    logic ram_we;
    logic [31:0] rnd;
    logic rng_step;

    gps_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_wp), .i_wdata(r_x),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );
    gps_rng u_rng (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(r_clear),
        .i_step(rng_step), .o_word(rnd));

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid && !r_clear;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = TW'(r_out);
    wire in_acc = s_axis_tvalid && s_axis_tready;
    wire cfg_acc = i_cfg_valid && o_cfg_ready;
    wire bypass = (r_ratio == UNITY_RATIO);

    // restart arithmetic
    logic [22:0] m23;
    assign m23 = rnd[31:9];
    logic [13:0] td;
    assign td = ({2'b0, r_frame} < r_tdisp) ? {2'b0, r_frame} : r_tdisp;
    logic [1:0] k;
    assign k = r_stage + 2'd1;
    logic signed [39:0] r36c;
    logic signed [21:0] p1;
    always_comb begin
        r36c = r_r36;
        if (r36c < 0) r36c = '0;
        if (r36c > 40'sh40_0000_0000) r36c = 40'sh40_0000_0000;
        p1 = 22'(r36c >>> 20) - 22'sd65536;
    end
    logic [31:0] r_start;

    // per-head read addressing
    logic [31:0] nd;
    logic [AW-1:0] rdi;
    always_comb begin
        nd = r_delay[r_h] + 32'(r_rate[r_h]);
        rdi = r_wp - nd[16+AW-1:16];
    end
    logic signed [SW+17:0] dif;
    logic signed [SW-1:0] d2v, d1v;
    assign d1v = r_z1 ? '0 : r_d1;
    assign d2v = (r_z1 || r_z2) ? '0 : $signed(ram_rdata);
    assign dif = (SW+18)'(d2v) - (SW+18)'(d1v);
    logic signed [SW+35:0] itp;
    assign itp = ((SW+36)'(d1v) <<< 16) + $signed({1'b0, r_frac}) * dif;

    logic signed [SW+44:0] yfull;
    logic signed [SW+44:0] ysh;
    assign yfull = r_sum + ((SW+45)'(1) <<< (39 - ISH));
    assign ysh = yfull >>> (40 - ISH);
    logic signed [24:0] ng;

    always_comb begin
        n_state = r_state;
        ram_raddr = rdi;
        ram_we = 1'b0;
        rng_step = 1'b0;
        ng = r_gain[r_h] + r_grate[r_h];
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = bypass ? ST_OUT
                                   : (r_gcnt == 0 ? ST_RESTART1 : ST_HEAD);
            ST_RESTART1: begin
                rng_step = (r_pdisp != 0);
                n_state = ST_RESTART2;
            end
            ST_RESTART2: begin
                rng_step = 1'b1;
                n_state = ST_RESTART3;
            end
            ST_RESTART3: n_state = ST_HEAD;
            ST_HEAD: begin
                ram_raddr = rdi;
                n_state = ST_TAPWAIT;
            end
            ST_TAPWAIT: begin
                ram_raddr = r_rd - 1'b1;
                n_state = ST_TAPACC;
            end
            ST_TAPACC: n_state = ST_MUL;
            ST_MUL: n_state = ST_SUM;
            ST_SUM: n_state = (r_h == 2'd3) ? ST_WRITE : ST_HEAD;
            ST_WRITE: begin
                ram_we = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= UNITY_RATIO; r_pdisp <= '0; r_tdisp <= '0;
            r_frame <= 12'd2048; r_ramp <= 23'd8192;
            r_clear <= 1'b1; r_ovalid <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_RATIO: begin
                        r_ratio <= i_cfg_data[15:0];
                        if (bypass && i_cfg_data[15:0] != UNITY_RATIO) r_clear <= 1'b1;
                    end
                    REG_PDISP: r_pdisp <= i_cfg_data[15:0];
                    REG_TDISP: r_tdisp <= i_cfg_data[13:0];
                    REG_FRAME: r_frame <= i_cfg_data[11:0];
                    REG_RAMP:  r_ramp <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clear) begin
            r_wp <= '0; r_warm <= '0; r_gcnt <= r_frame >> 2; r_stage <= 2'd3;
            for (int h = 0; h < 4; h++) begin
                r_delay[h] <= 32'h0002_0000;
                r_rate[h] <= 20'sd65536;
            end
            r_gain[0] <= 25'(GAIN_ONE / 2); r_gain[1] <= 25'(GAIN_ONE);
            r_gain[2] <= 25'(GAIN_ONE / 2); r_gain[3] <= '0;
            r_grate[0] <= -$signed({2'b0, r_ramp}); r_grate[1] <= -$signed({2'b0, r_ramp});
            r_grate[2] <= $signed({2'b0, r_ramp}); r_grate[3] <= $signed({2'b0, r_ramp});
        end else begin
            unique case (r_state)
                ST_IDLE: if (in_acc) begin
                    r_x <= s_axis_tdata[SW-1:0];
                    r_h <= 2'd0; r_sum <= '0;
                    r_r36 <= $signed({2'b0, r_ratio, 22'b0});
                    if (bypass) r_out <= s_axis_tdata[SW-1:0];
                    else if (r_gcnt != 0) begin
                        r_gcnt <= r_gcnt - 1'b1;
                        r_wp <= r_wp + 1'b1;
                        if (r_warm < WCW'(DELAY_DEPTH)) r_warm <= r_warm + 1'b1;
                    end
                end
                ST_RESTART1: if (r_pdisp != 0)
                    r_r36 <= r_r36 + $signed({1'b0, r_pdisp}) *
                             $signed({1'b0, m23} - 24'sd4194304);
                ST_RESTART2: begin
                    // frame * ratio excess wraps mod 2^32 like the delay itself
                    r_start <= ((p1 < 0) ? 32'h0002_0000
                        : 32'(r_frame) * 32'(p1) + 32'h0002_0000)
                        + 32'((37'(td) * 37'(m23)) >> 7);
                    r_rate[k] <= 20'(-p1);
                end
                ST_RESTART3: begin
                    r_stage <= k;
                    r_delay[k] <= r_start;
                    r_gain[k] <= '0;
                    r_grate[k] <= $signed({2'b0, r_ramp});
                    r_grate[k + 2'd2] <= -$signed({2'b0, r_ramp});
                    r_gcnt <= ((r_frame >> 2) == 0) ? 12'd0 : (r_frame >> 2) - 1'b1;
                    r_wp <= r_wp + 1'b1;
                    if (r_warm < WCW'(DELAY_DEPTH)) r_warm <= r_warm + 1'b1;
                end
                ST_HEAD: begin
                    r_delay[r_h] <= nd;
                    r_frac <= nd[15:0];
                    r_rd <= rdi;
                    r_warmf <= (r_warm < WCW'(DELAY_DEPTH));
                end
                ST_TAPWAIT: begin
                    r_d1 <= $signed(ram_rdata);
                    r_z1 <= r_warmf && (r_rd > r_wp);
                    r_z2 <= r_warmf && ((r_rd - 1'b1) > r_wp);
                end
                ST_TAPACC: r_interp <= (SW+19)'(itp >>> ISH);
                ST_MUL: r_prod <= r_interp * r_gain[r_h];
                ST_SUM: begin
                    r_sum <= r_sum + r_prod;
                    r_gain[r_h] <= (ng < 0) ? '0 : (ng > GAIN_ONE ? 25'(GAIN_ONE) : ng);
                    r_h <= r_h + 1'b1;
                end
                ST_WRITE: begin
                    if (ysh > (SW+45)'((1 <<< (SW-1)) - 1))
                        r_out <= {1'b0, {(SW-1){1'b1}}};
                    else if (ysh < -((SW+45)'(1) <<< (SW-1)))
                        r_out <= {1'b1, {(SW-1){1'b0}}};
                    else r_out <= ysh[SW-1:0];
                end
                default: ;
            endcase
        end
    end

    ap_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_out)) else $error("out");
    ap_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("acc");
    ap_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !bypass) else $error("we");
endmodule
`default_nettype wire
